// ===== design/assert_macros.svh =====
// Assertion helpers for the RTL files (included by tnm_back).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== design/tnm_pkg.sv =====
// ---------------------------------------------------------------------------
// tnm_pkg
// Types, constants and helpers of the top-k nearest merge unit.
// ---------------------------------------------------------------------------
`default_nettype none

package tnm_pkg;

    localparam int CAPACITY = 32;
    localparam int MAX_OUT  = 32;
    localparam int HOLD     = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
    localparam int IDX_W    = $clog2(HOLD);
    localparam int CNT_W    = $clog2(HOLD + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] REG_K_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NON_VECTOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONSISTENCY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL     = 2'd3;

    localparam logic [1:0] OP_CANDIDATE = 2'd0;
    localparam logic [1:0] OP_REPORT    = 2'd1;
    localparam logic [1:0] OP_FINISH    = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_CONSISTENCY = 2'd1;
    localparam logic [1:0] STATUS_NODE_ERROR  = 2'd2;

    localparam logic [4:0] ERR_NONE           = 5'd0;
    localparam logic [4:0] ERR_FAILED_PRECOND = 5'd9;

    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0] k_limit;
        logic       non_vector_mode;
        logic       consistency_enable;
        logic       partial_allowed;
    } cfg_t;

    typedef struct packed {
        logic [31:0] distance;
        logic [31:0] key;
    } entry_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] distance;
        logic [31:0] key_id;
        logic [31:0] count_in;
        logic [4:0]  node_status;
    } cmd_t;

    typedef struct packed {
        logic        entry_valid;
        logic [31:0] out_distance;
        logic [31:0] out_key;
        logic [1:0]  final_status;
        logic [4:0]  first_error;
        logic [47:0] count_total;
        logic        cancel;
        logic        overflow;
        logic        last;
    } result_t;

    typedef struct packed {
        logic ovf;
        logic succ;
        logic cons;
        logic err;
    } flags_t;

    // True when a is farther than b: larger distance, or equal distance and smaller key.
    function automatic logic farther(input entry_t a, input entry_t b);
        farther = (a.distance > b.distance)
                  || ((a.distance == b.distance) && (a.key < b.key));
    endfunction

endpackage

`default_nettype wire

// ===== design/topk_nearest_merge_unit.sv =====
// ---------------------------------------------------------------------------
// topk_nearest_merge_unit
// Merges shard candidates and keeps the k nearest entries of one query.
// ---------------------------------------------------------------------------
// Input channel: push/full queue. op 0 offers a candidate, op 1 a node
// report, op 2 finishes the query; op 3 is taken and ignored.
// Result channel: empty/pop queue. A report gives one result; a finish gives
// the held entries nearest first, or one status result; last marks the end.
// Configuration: wr_en/wr_index/wr_data, to be written only while idle; the
// block does not enforce this. A two-entry command queue and a four-entry
// result queue decouple the parts. The executor takes a command whenever it
// is idle and the result queue has room, pushing a report's result as it
// takes it. For a stored candidate the executor enters ST_INSERT, where the
// store is kept sorted one shift a cycle, farther entries moving up until the
// slot is found. A finish gives one status result or enters ST_DRAIN, which
// pushes the held entries while the result queue has room. A stalled receiver
// fills the result queue, then the executor and command queue hold, and full
// rises. Reset empties both queues and the query state, restores the register
// defaults; the store needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module topk_nearest_merge_unit
    import tnm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [1:0]            op,
    input  wire logic [31:0]           distance,
    input  wire logic [31:0]           key_id,
    input  wire logic [31:0]           count_in,
    input  wire logic [4:0]            node_status,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       entry_valid,
    output logic [31:0]                out_distance,
    output logic [31:0]                out_key,
    output logic [1:0]                 final_status,
    output logic [4:0]                 first_error,
    output logic [47:0]                count_total,
    output logic                       cancel,
    output logic                       overflow,
    output logic                       last,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    cfg_t    cfg_reg;
    cmd_t    cmd;
    logic    cmd_valid, cmd_pop;
    logic    res_full, res_push;
    result_t res_in, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{k_limit: 6'd10, non_vector_mode: 1'b0,
                         consistency_enable: 1'b0, partial_allowed: 1'b1};
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_K_LIMIT:     cfg_reg.k_limit            <= wr_data;
                REG_NON_VECTOR:  cfg_reg.non_vector_mode    <= wr_data[0];
                REG_CONSISTENCY: cfg_reg.consistency_enable <= wr_data[0];
                REG_PARTIAL:     cfg_reg.partial_allowed    <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tnm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .distance    (distance),
        .key_id      (key_id),
        .count_in    (count_in),
        .node_status (node_status),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    tnm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    tnm_out_fifo u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (res_push),
        .wr_data    (res_in),
        .fifo_full  (res_full),
        .fifo_empty (empty),
        .rd_en      (pop),
        .rd_data    (res_out)
    );

    assign entry_valid  = res_out.entry_valid;
    assign out_distance = res_out.out_distance;
    assign out_key      = res_out.out_key;
    assign final_status = res_out.final_status;
    assign first_error  = res_out.first_error;
    assign count_total  = res_out.count_total;
    assign cancel       = res_out.cancel;
    assign overflow     = res_out.overflow;
    assign last         = res_out.last;

endmodule

`default_nettype wire

// ===== design/tnm_front.sv =====
// ---------------------------------------------------------------------------
// tnm_front
// Accepts input items, drops unused opcodes and queues commands for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tnm_front
    import tnm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  op,
    input  wire logic [31:0] distance,
    input  wire logic [31:0] key_id,
    input  wire logic [31:0] count_in,
    input  wire logic [4:0]  node_status,
    output logic             cmd_valid,
    output cmd_t             cmd,
    input  wire logic        cmd_pop
);

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       accept, store;

    assign full      = (fill_reg == 2'd2);
    assign accept    = push && !full;
    // Opcode 3 is taken from the channel and has no effect.
    assign store     = accept && (op != 2'd3);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ store;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        fill_next   = fill_reg + {1'b0, store} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            queue_reg[wr_ptr_reg] <= '{op: op, distance: distance, key_id: key_id,
                                       count_in: count_in, node_status: node_status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/tnm_out_fifo.sv =====
// ---------------------------------------------------------------------------
// tnm_out_fifo
// Four-deep result queue between the back end and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module tnm_out_fifo
    import tnm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    output logic         fifo_full,
    output logic         fifo_empty,
    input  wire logic    rd_en,
    output result_t      rd_data
);

    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] fill_reg;
    logic       do_wr, do_rd;

    assign fifo_full  = (fill_reg == 3'd4);
    assign fifo_empty = (fill_reg == 3'd0);
    assign do_wr      = wr_en && !fifo_full;
    assign do_rd      = rd_en && !fifo_empty;
    assign rd_data    = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            queue_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            fill_reg   <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + {1'b0, do_wr};
            rd_ptr_reg <= rd_ptr_reg + {1'b0, do_rd};
            fill_reg   <= fill_reg + {2'b0, do_wr} - {2'b0, do_rd};
        end
    end

endmodule

`default_nettype wire

// ===== design/tnm_back.sv =====
// ---------------------------------------------------------------------------
// tnm_back
// Executes commands: keeps the entry store sorted nearest first, tracks node
// reports and streams the final results.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tnm_back
    import tnm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic cmd_valid,
    input  wire cmd_t cmd,
    output logic      cmd_pop,
    input  wire logic res_full,
    output logic      res_push,
    output result_t   res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_INSERT = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;

    localparam logic [CNT_W-1:0] HOLD_C = CNT_W'(HOLD);

    entry_t             store_reg [HOLD];
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [47:0]        sum_reg, sum_next;
    logic [4:0]         saved_err_reg, saved_err_next;
    flags_t             flags_reg, flags_next;
    entry_t             cand_reg, cand_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd_entry;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_addr;
    entry_t             mem_data;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   count_m1;
    logic [48:0]        sum_wide;
    logic               clear;

    assign count_m1 = count_reg - CNT_W'(1);
    assign limit    = (cfg.k_limit >= 6'(HOLD)) ? HOLD_C : cfg.k_limit[CNT_W-1:0];
    assign sum_wide = {1'b0, sum_reg} + {17'b0, cmd.count_in};

    always_comb
    begin
        unique case (state_reg)
            ST_INSERT: rd_addr = pos_reg - IDX_W'(1);
            ST_DRAIN:  rd_addr = idx_reg;
            default:   rd_addr = count_m1[IDX_W-1:0];
        endcase
    end

    assign rd_entry = store_reg[rd_addr];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        saved_err_next = saved_err_reg;
        flags_next     = flags_reg;
        cand_next      = cand_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res            = '0;
        mem_we         = 1'b0;
        mem_addr       = pos_reg;
        mem_data       = cand_reg;
        clear          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        OP_CANDIDATE:
                        begin
                            cand_next = '{distance: cmd.distance, key: cmd.key_id};
                            if (cfg.non_vector_mode)
                            begin
                                if (count_reg < HOLD_C)
                                begin
                                    pos_next   = count_reg[IDX_W-1:0];
                                    count_next = count_reg + CNT_W'(1);
                                    state_next = ST_INSERT;
                                end
                                else
                                begin
                                    flags_next.ovf = 1'b1;
                                end
                            end
                            else if (count_reg < limit)
                            begin
                                pos_next   = count_reg[IDX_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_INSERT;
                            end
                            // The farthest entry sits last; one with a strictly smaller distance replaces it.
                            else if ((count_reg != '0) && (cmd.distance < rd_entry.distance))
                            begin
                                pos_next   = count_m1[IDX_W-1:0];
                                state_next = ST_INSERT;
                            end
                        end
                        OP_REPORT:
                        begin
                            res.last = 1'b1;
                            res.overflow = flags_reg.ovf;
                            if (cmd.node_status != ERR_NONE)
                            begin
                                if (!flags_reg.err)
                                begin
                                    flags_next.err = 1'b1;
                                    saved_err_next = cmd.node_status;
                                end
                                if (cfg.consistency_enable
                                    && (cmd.node_status == ERR_FAILED_PRECOND))
                                begin
                                    flags_next.cons = 1'b1;
                                end
                                res.cancel = flags_next.cons || !cfg.partial_allowed;
                            end
                            else
                            begin
                                flags_next.succ = 1'b1;
                                sum_next = sum_wide[48] ? SUM_MAX : sum_wide[47:0];
                            end
                            res.first_error = saved_err_next;
                            res.count_total = sum_next;
                            res_push = 1'b1;
                        end
                        OP_FINISH:
                        begin
                            res.first_error = saved_err_reg;
                            res.count_total = sum_reg;
                            res.overflow    = flags_reg.ovf;
                            res.last        = 1'b1;
                            if (flags_reg.cons)
                            begin
                                res.final_status = STATUS_CONSISTENCY;
                                res_push = 1'b1;
                                clear = 1'b1;
                            end
                            else if (flags_reg.err
                                     && (!cfg.partial_allowed || !flags_reg.succ))
                            begin
                                res.final_status = STATUS_NODE_ERROR;
                                res_push = 1'b1;
                                clear = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                res.final_status = STATUS_OK;
                                res_push = 1'b1;
                                clear = 1'b1;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_DRAIN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_INSERT:
            begin
                // Shift farther entries up one place until the slot is found.
                mem_we = 1'b1;
                if ((pos_reg != '0) && farther(rd_entry, cand_reg))
                begin
                    mem_data = rd_entry;
                    pos_next = pos_reg - IDX_W'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (!res_full)
                begin
                    res_push         = 1'b1;
                    res.entry_valid  = 1'b1;
                    res.out_distance = rd_entry.distance;
                    res.out_key      = rd_entry.key;
                    res.final_status = STATUS_OK;
                    res.first_error  = saved_err_reg;
                    res.count_total  = sum_reg;
                    res.overflow     = flags_reg.ovf;
                    res.last         = ({1'b0, idx_reg} == count_m1);
                    if (res.last)
                    begin
                        clear      = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear)
        begin
            count_next     = '0;
            sum_next       = '0;
            saved_err_next = ERR_NONE;
            flags_next     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_addr] <= mem_data;
        end
        cand_reg <= cand_next;
        pos_reg  <= pos_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            saved_err_reg <= ERR_NONE;
            flags_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            saved_err_reg <= saved_err_next;
            flags_reg     <= flags_next;
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > HOLD_C)
    `ASSERT_NEVER(a_push_when_full, clk, rst_n, res_push && res_full)
    `ASSERT_NEVER(a_drain_empty, clk, rst_n, (state_reg == ST_DRAIN) && (count_reg == '0))
    `ASSERT_NEVER(a_insert_beyond, clk, rst_n,
                  (state_reg == ST_INSERT) && ({1'b0, pos_reg} >= count_reg))
    `ASSERT_ALWAYS(a_pop_only_idle, clk, rst_n, !cmd_pop || (state_reg == ST_IDLE))

endmodule

`default_nettype wire

// ===== verif/tb_topk_nearest_merge_unit.sv =====
// ---------------------------------------------------------------------------
// tb_topk_nearest_merge_unit
// Drives candidates, node reports and finishes through the push/full port,
// predicts most results from a local model of the merge state (some rows give
// the expected result directly), and checks each popped result field by field
// under several register settings and idling patterns, including a long receiver stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_topk_nearest_merge_unit
    import tnm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [1:0]            op;
    logic [31:0]           distance;
    logic [31:0]           key_id;
    logic [31:0]           count_in;
    logic [4:0]            node_status;
    logic                  empty;
    logic                  pop;
    logic                  entry_valid;
    logic [31:0]           out_distance;
    logic [31:0]           out_key;
    logic [1:0]            final_status;
    logic [4:0]            first_error;
    logic [47:0]           count_total;
    logic                  cancel;
    logic                  overflow;
    logic                  last;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         SETTLE_CYCLES = 80;

    topk_nearest_merge_unit DUT (.*);

    typedef struct {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [5:0]           reg_value;
        cmd_t                 item;
        logic                 typed;
        result_t              want;
    } stim_row_t;

    // Local copy of the query state and the registers.
    entry_t      kept[HOLD];
    int unsigned kept_count;
    logic [47:0] match_sum;
    logic [4:0]  saved_code;
    flags_t      qflags;
    cfg_t        regs;

    result_t     pending_results[$];
    stim_row_t   stim_table[$];
    int          failures;
    int          tx_idle_pct;
    int          rx_stall_pct;
    int          rx_hold_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #30ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Lower rank means nearer: larger key wins a distance tie.
    function automatic logic [63:0] nearness_rank(input entry_t e);
        nearness_rank = {e.distance, ~e.key};
    endfunction

    function automatic cmd_t make_cmd(input logic [1:0] o, input logic [31:0] d,
                                      input logic [31:0] k, input logic [31:0] c,
                                      input logic [4:0] e);
        cmd_t r;
        r.op = o;
        r.distance = d;
        r.key_id = k;
        r.count_in = c;
        r.node_status = e;
        return r;
    endfunction

    function automatic result_t status_result(input logic [1:0] st, input logic [4:0] fe,
                                              input logic [47:0] tot, input logic can);
        result_t r;
        r = '0;
        r.final_status = st;
        r.first_error = fe;
        r.count_total = tot;
        r.cancel = can;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic result_t merge_result(input logic valid, input entry_t e,
                                             input logic [1:0] st, input logic can,
                                             input logic lst);
        result_t r;
        r.entry_valid = valid;
        r.out_distance = valid ? e.distance : 32'd0;
        r.out_key = valid ? e.key : 32'd0;
        r.final_status = st;
        r.first_error = saved_code;
        r.count_total = match_sum;
        r.cancel = can;
        r.overflow = qflags.ovf;
        r.last = lst;
        return r;
    endfunction

    function automatic void clear_query();
        kept_count = 0;
        match_sum = '0;
        saved_code = ERR_NONE;
        qflags = '0;
    endfunction

    // Updates the query state for one accepted item and returns its results.
    function automatic void merge_item(input cmd_t c, output result_t res[$]);
        entry_t      cand;
        entry_t      order[HOLD];
        entry_t      v;
        int unsigned lim;
        int unsigned worst;
        int          j;
        logic        can;
        logic [48:0] s;
        res = {};
        cand.distance = c.distance;
        cand.key = c.key_id;
        unique case (c.op)
            OP_CANDIDATE:
            begin
                if (regs.non_vector_mode)
                begin
                    if (kept_count < HOLD)
                    begin
                        kept[kept_count] = cand;
                        kept_count++;
                    end
                    else
                        qflags.ovf = 1'b1;
                end
                else
                begin
                    lim = (regs.k_limit < HOLD) ? regs.k_limit : HOLD;
                    if (kept_count < lim)
                    begin
                        kept[kept_count] = cand;
                        kept_count++;
                    end
                    else if (kept_count != 0)
                    begin
                        worst = 0;
                        for (int i = 1; i < kept_count; i++)
                            if (nearness_rank(kept[i]) > nearness_rank(kept[worst]))
                                worst = i;
                        if (cand.distance < kept[worst].distance)
                            kept[worst] = cand;
                    end
                end
            end
            OP_REPORT:
            begin
                can = 1'b0;
                if (c.node_status != ERR_NONE)
                begin
                    if (!qflags.err)
                    begin
                        qflags.err = 1'b1;
                        saved_code = c.node_status;
                    end
                    if (regs.consistency_enable && c.node_status == ERR_FAILED_PRECOND)
                        qflags.cons = 1'b1;
                    can = qflags.cons || !regs.partial_allowed;
                end
                else
                begin
                    qflags.succ = 1'b1;
                    s = {1'b0, match_sum} + c.count_in;
                    match_sum = (s > SUM_MAX) ? SUM_MAX : s[47:0];
                end
                res.push_back(merge_result(1'b0, cand, STATUS_OK, can, 1'b1));
            end
            OP_FINISH:
            begin
                if (qflags.cons)
                    res.push_back(merge_result(1'b0, cand, STATUS_CONSISTENCY, 1'b0, 1'b1));
                else if (qflags.err && (!regs.partial_allowed || !qflags.succ))
                    res.push_back(merge_result(1'b0, cand, STATUS_NODE_ERROR, 1'b0, 1'b1));
                else if (kept_count == 0)
                    res.push_back(merge_result(1'b0, cand, STATUS_OK, 1'b0, 1'b1));
                else
                begin
                    order = kept;
                    for (int i = 1; i < kept_count; i++)
                    begin
                        v = order[i];
                        j = i;
                        while (j > 0 && nearness_rank(order[j-1]) > nearness_rank(v))
                        begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = v;
                    end
                    for (int i = 0; i < kept_count; i++)
                        res.push_back(merge_result(1'b1, order[i], STATUS_OK, 1'b0,
                                                   i + 1 == kept_count));
                end
                clear_query();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Called at a rising edge; leaves push high with the item until it is taken.
    task automatic send_item(input cmd_t c, input logic typed, input result_t want);
        result_t res[$];
        logic    taken;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        push <= 1'b1;
        op <= c.op;
        distance <= c.distance;
        key_id <= c.key_id;
        count_in <= c.count_in;
        node_status <= c.node_status;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            if (taken)
            begin
                merge_item(c, res);
                if (typed)
                    pending_results.push_back(want);
                else
                    foreach (res[i])
                        pending_results.push_back(res[i]);
            end
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        unique case (idx)
            REG_K_LIMIT:     regs.k_limit = val;
            REG_NON_VECTOR:  regs.non_vector_mode = val[0];
            REG_CONSISTENCY: regs.consistency_enable = val[0];
            default:         regs.partial_allowed = val[0];
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // Receiver: pop decided at the rising edge, result sampled at the falling edge.
    initial
    begin
        result_t w;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(0, 99) >= rx_stall_pct);
            @(negedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result popped with nothing expected");
                    failures++;
                end
                else
                begin
                    w = pending_results.pop_front();
                    compare_field("entry_valid", w.entry_valid, entry_valid);
                    compare_field("out_distance", w.out_distance, out_distance);
                    compare_field("out_key", w.out_key, out_key);
                    compare_field("final_status", w.final_status, final_status);
                    compare_field("first_error", w.first_error, first_error);
                    compare_field("count_total", w.count_total, count_total);
                    compare_field("cancel", w.cancel, cancel);
                    compare_field("overflow", w.overflow, overflow);
                    compare_field("last", w.last, last);
                end
            end
        end
    end

    function automatic void add_item(input cmd_t c);
        stim_row_t r;
        r = '{default: '0};
        r.item = c;
        stim_table.push_back(r);
    endfunction

    function automatic void add_typed(input cmd_t c, input result_t want);
        stim_row_t r;
        r = '{default: '0};
        r.item = c;
        r.typed = 1'b1;
        r.want = want;
        stim_table.push_back(r);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] val);
        stim_row_t r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        stim_table.push_back(r);
    endfunction

    function automatic logic [31:0] pick_word();
        return ($urandom_range(0, 1) != 0) ? 32'($urandom_range(0, 7)) : $urandom;
    endfunction

    initial
    begin
        cmd_t        c;
        result_t     none;
        int          sent;
        int          n_cand;
        int          n_rep;
        logic [4:0]  code;

        rst_n = 1'b0;
        push = 1'b0;
        op = OP_CANDIDATE;
        distance = '0;
        key_id = '0;
        count_in = '0;
        node_status = ERR_NONE;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        failures = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 0;
        none = '0;
        regs.k_limit = 6'd10;
        regs.non_vector_mode = 1'b0;
        regs.consistency_enable = 1'b0;
        regs.partial_allowed = 1'b1;
        clear_query();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults after reset.
        add_typed(make_cmd(OP_FINISH, 0, 0, 0, 0), status_result(STATUS_OK, 0, 0, 0));
        add_typed(make_cmd(OP_REPORT, 0, 0, 32'hFFFF_FFFF, ERR_NONE),
                  status_result(STATUS_OK, 0, 48'hFFFF_FFFF, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'd0, 32'd0, 0, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'd5, 32'd7, 0, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'd5, 32'd3, 0, 0));
        add_item(make_cmd(OP_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
        add_typed(make_cmd(OP_REPORT, 0, 0, 0, 5'd16),
                  status_result(STATUS_OK, 5'd16, 48'hFFFF_FFFF, 0));
        add_item(make_cmd(OP_FINISH, 0, 0, 0, 0));
        // A single slot: an equal distance never evicts, a smaller one does.
        add_write(REG_K_LIMIT, 6'd1);
        add_item(make_cmd(OP_CANDIDATE, 32'd10, 32'd1, 0, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'd10, 32'd2, 0, 0));
        add_item(make_cmd(OP_CANDIDATE, 32'd9, 32'd0, 0, 0));
        add_item(make_cmd(OP_FINISH, 0, 0, 0, 0));
        // A zero limit drops every candidate.
        add_write(REG_K_LIMIT, 6'd0);
        add_item(make_cmd(OP_CANDIDATE, 32'd1, 32'd1, 0, 0));
        add_typed(make_cmd(OP_FINISH, 0, 0, 0, 0), status_result(STATUS_OK, 0, 0, 0));
        add_write(REG_K_LIMIT, 6'd63);
        add_write(REG_PARTIAL, 6'd0);
        add_typed(make_cmd(OP_REPORT, 0, 0, 32'd3, ERR_NONE), status_result(STATUS_OK, 0, 3, 0));
        add_typed(make_cmd(OP_REPORT, 0, 0, 0, 5'd1), status_result(STATUS_OK, 5'd1, 3, 1));
        add_typed(make_cmd(OP_FINISH, 0, 0, 0, 0), status_result(STATUS_NODE_ERROR, 5'd1, 3, 0));
        add_write(REG_CONSISTENCY, 6'd1);
        add_write(REG_PARTIAL, 6'd1);
        add_typed(make_cmd(OP_REPORT, 0, 0, 0, ERR_FAILED_PRECOND),
                  status_result(STATUS_OK, ERR_FAILED_PRECOND, 0, 1));
        add_typed(make_cmd(OP_REPORT, 0, 0, 0, 5'd4),
                  status_result(STATUS_OK, ERR_FAILED_PRECOND, 0, 1));
        add_typed(make_cmd(OP_FINISH, 0, 0, 0, 0),
                  status_result(STATUS_CONSISTENCY, ERR_FAILED_PRECOND, 0, 0));
        // Only failed nodes, partial allowed: still a node error.
        add_typed(make_cmd(OP_REPORT, 0, 0, 0, 5'd2), status_result(STATUS_OK, 5'd2, 0, 0));
        add_typed(make_cmd(OP_FINISH, 0, 0, 0, 0), status_result(STATUS_NODE_ERROR, 5'd2, 0, 0));
        // Non-vector mode past capacity sets overflow.
        add_write(REG_NON_VECTOR, 6'd1);
        for (int i = 0; i < HOLD + 2; i++)
            add_item(make_cmd(OP_CANDIDATE, $urandom, $urandom, 0, 0));
        add_item(make_cmd(OP_REPORT, 0, 0, 32'd1, ERR_NONE));
        add_item(make_cmd(OP_FINISH, 0, 0, 0, 0));

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_write)
            begin
                wait_drained();
                write_reg(stim_table[i].reg_index, stim_table[i].reg_value);
            end
            else
                send_item(stim_table[i].item, stim_table[i].typed, stim_table[i].want);
        end

        // Random queries, one register setting and idling pattern per phase.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            unique case (ph)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    write_reg(REG_NON_VECTOR, 6'd0);
                    write_reg(REG_CONSISTENCY, 6'd0);
                    write_reg(REG_K_LIMIT, 6'd32);
                    write_reg(REG_PARTIAL, 6'd1);
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_stall_pct = 0;
                    write_reg(REG_K_LIMIT, 6'($urandom_range(1, 8)));
                    write_reg(REG_CONSISTENCY, 6'd1);
                    write_reg(REG_PARTIAL, 6'd0);
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 48;
                    write_reg(REG_NON_VECTOR, 6'd1);
                    write_reg(REG_CONSISTENCY, 6'd0);
                    write_reg(REG_PARTIAL, 6'd1);
                end
                default:
                begin
                    tx_idle_pct = 20;
                    rx_stall_pct = 20;
                    write_reg(REG_NON_VECTOR, 6'd0);
                    write_reg(REG_K_LIMIT, 6'd63);
                    write_reg(REG_CONSISTENCY, 6'($urandom_range(0, 1)));
                end
            endcase
            sent = 0;
            while (sent < 80)
            begin
                n_cand = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 12);
                n_rep = $urandom_range(0, 3);
                for (int i = 0; i < n_cand + n_rep; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(make_cmd(OP_IGNORED, $urandom, $urandom, $urandom,
                                           5'($urandom)), 1'b0, none);
                    if (i < n_cand)
                        c = make_cmd(OP_CANDIDATE, pick_word(), pick_word(), $urandom, 0);
                    else
                    begin
                        code = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(1, 16))
                                                           : ERR_NONE;
                        if ($urandom_range(0, 30) == 0)
                            code = 5'd31;
                        c = make_cmd(OP_REPORT, $urandom, $urandom, $urandom, code);
                    end
                    send_item(c, 1'b0, none);
                    sent++;
                end
                send_item(make_cmd(OP_FINISH, $urandom, $urandom, $urandom, 5'($urandom)),
                          1'b0, none);
                sent++;
            end
        end

        // Long receiver hold-off while reports keep coming, so the input backs up.
        wait_drained();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_cycles = 300;
        for (int i = 0; i < 12; i++)
            send_item(make_cmd(OP_REPORT, 0, 0, $urandom, ERR_NONE), 1'b0, none);
        send_item(make_cmd(OP_FINISH, 0, 0, 0, 0), 1'b0, none);

        wait_drained();
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

// ===== topk_nearest_merge_unit.f =====
+incdir+design
design/tnm_pkg.sv
design/tnm_front.sv
design/tnm_out_fifo.sv
design/tnm_back.sv
design/topk_nearest_merge_unit.sv
verif/tb_topk_nearest_merge_unit.sv
